>>> src/shp3x3_pkg.sv
package shp3x3_pkg;

    // Default sizing of the line stores.
    localparam int DEFAULT_MAX_WIDTH    = 2048;
    localparam int DEFAULT_MAX_CHANNELS = 4;

    // Field and port widths.
    localparam int SAMPLE_W   = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int CH_W       = 2;
    localparam int NCH_W      = 3;
    localparam int LEN_W      = 15;
    localparam int ACC_W      = 12;

    // Register limits and reset values.
    localparam int MIN_WIDTH      = 3;
    localparam int MIN_HEIGHT     = 3;
    localparam int MAX_HEIGHT     = 4095;
    localparam int MIN_CHANNELS   = 1;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int RESET_CHANNELS = 1;

    // Filter gain on the centre tap.
    localparam int CENTRE_GAIN = 5;

    // Reciprocal of three, scaled by two to the RECIP3_SHIFT, for positions below 32768.
    localparam int RECIP3       = 21846;
    localparam int RECIP3_W     = 15;
    localparam int RECIP3_SHIFT = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH   = 2'd0,
        CFG_IMAGE_HEIGHT  = 2'd1,
        CFG_CHANNEL_COUNT = 2'd2
    } cfg_reg_t;

endpackage

>>> src/sharpen_3x3_cross_filter.sv
// Streaming 3x3 cross sharpening filter (5*centre minus up, down, left and right,
// saturated to 0..255) for 8-bit images in raster order with channels interleaved.
// One item is accepted per clock cycle; the only pause is when a result sits in the
// output register under stall while the item behind it also has a result to deliver.
// A result passes the stage 1 and output registers, and belongs to the
// position one row up and one pixel left; the first row and column give zero, and the
// last row and last pixel column are never delivered. Two line stores of
// MAX_WIDTH*MAX_CHANNELS bytes hold the previous rows: each is a synchronous memory
// read at accept time and written from stage 1, with forwarding from the write
// stage. Stores are not cleared after reset; the first two rows after reset or a
// geometry change read back stale data only where the output is forced to zero.
module sharpen_3x3_cross_filter #(
    parameter int MAX_WIDTH    = shp3x3_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_CHANNELS = shp3x3_pkg::DEFAULT_MAX_CHANNELS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [shp3x3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [shp3x3_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [shp3x3_pkg::SAMPLE_W-1:0]     sample,
    input  logic                                start_of_frame,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [shp3x3_pkg::SAMPLE_W-1:0]     value,
    output logic [shp3x3_pkg::ROW_W-1:0]        out_row,
    output logic [shp3x3_pkg::COL_W-1:0]        out_column,
    output logic [shp3x3_pkg::CH_W-1:0]         out_channel,
    output logic                                frame_last
);

    localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = ADDR_W + shp3x3_pkg::RECIP3_W;
    localparam int SW     = shp3x3_pkg::SAMPLE_W;

    // Configuration registers.
    logic [shp3x3_pkg::CFG_DATA_W-1:0] image_width_reg;
    logic [shp3x3_pkg::CFG_DATA_W-1:0] image_height_reg;
    logic [shp3x3_pkg::NCH_W-1:0]      channel_count_reg;

    // Clamped geometry.
    logic [shp3x3_pkg::CFG_DATA_W-1:0] w_c;
    logic [shp3x3_pkg::ROW_W-1:0]      h_c;
    logic [shp3x3_pkg::NCH_W-1:0]      nch_c;
    logic [shp3x3_pkg::LEN_W-1:0]      row_len;

    // Position counters.
    logic [ADDR_W-1:0]            pos_reg;
    logic [ADDR_W-1:0]            pos_next;
    logic [shp3x3_pkg::ROW_W-1:0] row_reg;
    logic [shp3x3_pkg::ROW_W-1:0] row_next;

    // Stage 0 decode of the incoming item.
    logic [ADDR_W-1:0]            p_cur;
    logic [ADDR_W-1:0]            p_left;
    logic [shp3x3_pkg::ROW_W-1:0] r_cur;
    logic [ADDR_W-1:0]            col_cur;
    logic [shp3x3_pkg::CH_W-1:0]  ch_cur;
    logic [PROD_W-1:0]            prod3;
    logic [ADDR_W-1:0]            col3;
    logic [ADDR_W-1:0]            rem3;
    logic                         has_left;
    logic                         zero_col;
    logic                         emit_cur;
    logic                         zero_cur;
    logic                         last_cur;

    // Handshake.
    logic accept;
    logic s1_go;
    logic out_take;

    // Stage 1 registers.
    logic                         s1_valid_reg;
    logic [ADDR_W-1:0]            s1_p_reg;
    logic [SW-1:0]                s1_smp_reg;
    logic [shp3x3_pkg::CH_W-1:0]  s1_ch_reg;
    logic [shp3x3_pkg::ROW_W-1:0] s1_row_reg;
    logic [shp3x3_pkg::COL_W-1:0] s1_col_reg;
    logic                         s1_emit_reg;
    logic                         s1_zero_reg;
    logic                         s1_last_reg;
    logic                         fwd_right_reg;
    logic                         fwd_down_reg;
    logic                         fwd_up_reg;
    logic [SW-1:0]                fwd_right_data_reg;
    logic [SW-1:0]                fwd_down_data_reg;
    logic [SW-1:0]                fwd_up_data_reg;

    // Line stores and their registered read data.
    logic [SW-1:0] mid_mem   [DEPTH];
    logic [SW-1:0] above_mem [DEPTH];
    logic [SW-1:0] mid_rd_reg;
    logic [SW-1:0] down_rd_reg;
    logic [SW-1:0] above_rd_reg;

    // Per-channel window taps.
    logic [SW-1:0] centre_reg [MAX_CHANNELS];
    logic [SW-1:0] left_reg   [MAX_CHANNELS];
    logic [SW-1:0] up_reg     [MAX_CHANNELS];

    // Stage 1 datapath.
    logic [SW-1:0]                 right_s1;
    logic [SW-1:0]                 down_s1;
    logic [SW-1:0]                 up_new_s1;
    logic [SW-1:0]                 tap_c;
    logic [SW-1:0]                 tap_l;
    logic [SW-1:0]                 tap_u;
    logic [shp3x3_pkg::ACC_W-1:0]  acc;
    logic [SW-1:0]                 sat;

    // Output registers.
    logic                         out_valid_reg;
    logic [SW-1:0]                value_reg;
    logic [shp3x3_pkg::ROW_W-1:0] out_row_reg;
    logic [shp3x3_pkg::COL_W-1:0] out_column_reg;
    logic [shp3x3_pkg::CH_W-1:0]  out_channel_reg;
    logic                         frame_last_reg;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= shp3x3_pkg::CFG_DATA_W'(shp3x3_pkg::RESET_WIDTH);
            image_height_reg  <= shp3x3_pkg::CFG_DATA_W'(shp3x3_pkg::RESET_HEIGHT);
            channel_count_reg <= shp3x3_pkg::NCH_W'(shp3x3_pkg::RESET_CHANNELS);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                shp3x3_pkg::CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                shp3x3_pkg::CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                shp3x3_pkg::CFG_CHANNEL_COUNT:
                    channel_count_reg <= cfg_data[shp3x3_pkg::NCH_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the registers to the range the store and counters support.
    always_comb
    begin
        if (32'(image_width_reg) < shp3x3_pkg::MIN_WIDTH)
            w_c = shp3x3_pkg::CFG_DATA_W'(shp3x3_pkg::MIN_WIDTH);
        else if (32'(image_width_reg) > MAX_WIDTH)
            w_c = shp3x3_pkg::CFG_DATA_W'(MAX_WIDTH);
        else
            w_c = image_width_reg;

        if (32'(image_height_reg) < shp3x3_pkg::MIN_HEIGHT)
            h_c = shp3x3_pkg::ROW_W'(shp3x3_pkg::MIN_HEIGHT);
        else
            h_c = image_height_reg;

        if (32'(channel_count_reg) < shp3x3_pkg::MIN_CHANNELS)
            nch_c = shp3x3_pkg::NCH_W'(shp3x3_pkg::MIN_CHANNELS);
        else if (32'(channel_count_reg) > MAX_CHANNELS)
            nch_c = shp3x3_pkg::NCH_W'(MAX_CHANNELS);
        else
            nch_c = channel_count_reg;

        row_len = shp3x3_pkg::LEN_W'(w_c) * shp3x3_pkg::LEN_W'(nch_c);
    end

    // Position of the incoming item, with frame restart and wrap past the frame.
    always_comb
    begin
        if (start_of_frame || (32'(pos_reg) >= 32'(row_len)))
            p_cur = '0;
        else
            p_cur = pos_reg;

        if (start_of_frame || (row_reg >= h_c))
            r_cur = '0;
        else
            r_cur = row_reg;

        p_left = p_cur - ADDR_W'(nch_c);

        if (32'(p_cur) + 1 >= 32'(row_len))
        begin
            pos_next = '0;
            if (32'(r_cur) + 1 >= 32'(h_c))
                row_next = '0;
            else
                row_next = r_cur + 1'b1;
        end
        else
        begin
            pos_next = p_cur + 1'b1;
            row_next = r_cur;
        end
    end

    // Split the position into pixel column and channel; three uses the reciprocal.
    always_comb
    begin
        prod3 = PROD_W'(p_cur) * PROD_W'(shp3x3_pkg::RECIP3);
        col3  = ADDR_W'(prod3 >> shp3x3_pkg::RECIP3_SHIFT);
        rem3  = p_cur - ADDR_W'(col3 * ADDR_W'(3));

        case (nch_c)
            3'd2:
            begin
                col_cur = p_cur >> 1;
                ch_cur  = {1'b0, p_cur[0]};
            end
            3'd3:
            begin
                col_cur = col3;
                ch_cur  = rem3[1:0];
            end
            3'd4:
            begin
                col_cur = p_cur >> 2;
                ch_cur  = p_cur[1:0];
            end
            default:
            begin
                col_cur = p_cur;
                ch_cur  = '0;
            end
        endcase

        has_left = 32'(p_cur) >= 32'(nch_c);
        zero_col = 32'(p_cur) < 2 * 32'(nch_c);
        emit_cur = (r_cur != '0) && has_left;
        zero_cur = (r_cur == shp3x3_pkg::ROW_W'(1)) || zero_col;
        last_cur = (32'(r_cur) == 32'(h_c) - 1) && (32'(p_cur) == 32'(row_len) - 1);
    end

    // The stage 1 item leaves unless its result finds the output register held.
    assign s1_go    = s1_valid_reg && !(s1_emit_reg && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && s1_emit_reg && out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            row_reg <= row_next;
        end
    end

    // Stage 1 capture; forwarding covers the write that lands on the same edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_p_reg           <= p_cur;
            s1_smp_reg         <= sample;
            s1_ch_reg          <= ch_cur;
            s1_row_reg         <= r_cur - 1'b1;
            s1_col_reg         <= shp3x3_pkg::COL_W'(col_cur - 1'b1);
            s1_emit_reg        <= emit_cur;
            s1_zero_reg        <= zero_cur;
            s1_last_reg        <= last_cur;
            fwd_right_reg      <= s1_valid_reg && (s1_p_reg == p_cur);
            fwd_down_reg       <= s1_valid_reg && (s1_p_reg == p_left);
            fwd_up_reg         <= s1_valid_reg && (s1_p_reg == p_cur);
            fwd_right_data_reg <= s1_smp_reg;
            fwd_down_data_reg  <= s1_smp_reg;
            fwd_up_data_reg    <= right_s1;
        end
    end

    // Line stores: reads at accept, write-back from stage 1.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_rd_reg   <= mid_mem[p_cur];
            down_rd_reg  <= mid_mem[p_left];
            above_rd_reg <= above_mem[p_cur];
        end
        if (s1_go)
        begin
            mid_mem[s1_p_reg]   <= s1_smp_reg;
            above_mem[s1_p_reg] <= right_s1;
        end
    end

    // Stage 1 operands.
    always_comb
    begin
        right_s1  = fwd_right_reg ? fwd_right_data_reg : mid_rd_reg;
        down_s1   = fwd_down_reg  ? fwd_down_data_reg  : down_rd_reg;
        up_new_s1 = fwd_up_reg    ? fwd_up_data_reg    : above_rd_reg;

        tap_c = '0;
        tap_l = '0;
        tap_u = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
        begin
            if (32'(s1_ch_reg) == i)
            begin
                tap_c = centre_reg[i];
                tap_l = left_reg[i];
                tap_u = up_reg[i];
            end
        end
    end

    // Cross kernel and saturation; the sum stays within a 12-bit signed range.
    always_comb
    begin
        acc = shp3x3_pkg::ACC_W'(tap_c) * shp3x3_pkg::ACC_W'(shp3x3_pkg::CENTRE_GAIN)
            - shp3x3_pkg::ACC_W'(tap_l) - shp3x3_pkg::ACC_W'(right_s1)
            - shp3x3_pkg::ACC_W'(tap_u) - shp3x3_pkg::ACC_W'(down_s1);

        if (acc[shp3x3_pkg::ACC_W-1])
            sat = '0;
        else if (acc > shp3x3_pkg::ACC_W'(255))
            sat = '1;
        else
            sat = acc[SW-1:0];
    end

    // Window taps shift along one pixel in the item's own channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                centre_reg[i] <= '0;
                left_reg[i]   <= '0;
                up_reg[i]     <= '0;
            end
        end
        else if (s1_go)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                if (32'(s1_ch_reg) == i)
                begin
                    left_reg[i]   <= centre_reg[i];
                    centre_reg[i] <= right_s1;
                    up_reg[i]     <= up_new_s1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && s1_emit_reg)
            out_valid_reg <= 1'b1;
        else if (out_take)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            value_reg       <= s1_zero_reg ? '0 : sat;
            out_row_reg     <= s1_row_reg;
            out_column_reg  <= s1_col_reg;
            out_channel_reg <= s1_ch_reg;
            frame_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = value_reg;
    assign out_row     = out_row_reg;
    assign out_column  = out_column_reg;
    assign out_channel = out_channel_reg;
    assign frame_last  = frame_last_reg;

    // The input is held back only behind a full, stalled output register.
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid_reg)
        else $error("input stalled without a held result");

    // An accepted item always occupies stage 1 on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> s1_valid_reg)
        else $error("accepted item lost before stage 1");

    // A result leaving stage 1 is present at the output on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_emit_reg) |=> out_valid_reg)
        else $error("result from stage 1 not presented");

    // A stage 1 item with a result never overwrites a held output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_emit_reg) |-> (!out_valid_reg || !out_stall))
        else $error("held result overwritten");

endmodule
